// ===== design/apl_pkg.sv =====
// ----------------------------------------------------------------------------
// apl_pkg
// Shared types and format constants for the audio peak level meter.
// ----------------------------------------------------------------------------
package apl_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned LEVEL_W  = 17;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned CFG_W    = 2;
    localparam int unsigned DIVD_W   = SAMPLE_W + LEVEL_W;

    localparam logic [1:0] SZ_8     = 2'd0;
    localparam logic [1:0] SZ_16    = 2'd1;
    localparam logic [1:0] SZ_32    = 2'd2;

    localparam logic [1:0] TY_UNS   = 2'd0;
    localparam logic [1:0] TY_SGN   = 2'd1;
    localparam logic [1:0] TY_FLT   = 2'd2;

    localparam logic [1:0] CFG_SIZE = 2'd0;
    localparam logic [1:0] CFG_TYPE = 2'd1;
    localparam logic [1:0] CFG_BE   = 2'd2;

    localparam logic [31:0] FS_8U   = 32'd255;
    localparam logic [31:0] FS_8S   = 32'd127;
    localparam logic [31:0] FS_16U  = 32'd65535;
    localparam logic [31:0] FS_16S  = 32'd32767;
    localparam logic [31:0] FS_32U  = 32'hffff_ffff;
    localparam logic [31:0] FS_32S  = 32'h7fff_ffff;

    localparam logic [16:0] LEVEL_MAX = 17'd65536;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [16:0] level;
        logic        format_ok;
    } t_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== design/apl_dec.sv =====
// ----------------------------------------------------------------------------
// apl_dec
// Sample decoder: byte order, sign and float handling to an unsigned
// magnitude, plus the full scale of the configured format.
// ----------------------------------------------------------------------------
module apl_dec (
    input  logic [31:0] i_sample,
    input  logic [1:0]  i_size,
    input  logic [1:0]  i_type,
    input  logic        i_big,
    output logic [31:0] o_mag,
    output logic [31:0] o_fs
);
    import apl_pkg::*;

    logic [15:0] w_v16;
    logic [31:0] w_v32;
    logic [7:0]  w_exp;
    logic [23:0] w_man;
    logic [31:0] w_fmag;
    logic [7:0]  w_shl;
    logic [7:0]  w_shr;

    always_comb begin
        o_fs = '0;
        case (i_size)
            SZ_8: begin
                if (i_type == TY_UNS) o_fs = FS_8U;
                else if (i_type == TY_SGN) o_fs = FS_8S;
            end
            SZ_16: begin
                if (i_type == TY_UNS) o_fs = FS_16U;
                else if (i_type == TY_SGN) o_fs = FS_16S;
            end
            SZ_32: begin
                if (i_type == TY_UNS) o_fs = FS_32U;
                else if (i_type == TY_SGN || i_type == TY_FLT) o_fs = FS_32S;
            end
            default: o_fs = '0;
        endcase
    end

    assign w_v16 = i_big ? {i_sample[7:0], i_sample[15:8]} : i_sample[15:0];
    assign w_v32 = i_big ? {i_sample[7:0], i_sample[15:8], i_sample[23:16],
                            i_sample[31:24]} : i_sample;

    // float: trunc(|f| * 2^31) saturated
    assign w_exp = w_v32[30:23];
    assign w_man = {1'b1, w_v32[22:0]};
    assign w_shl = w_exp - 8'd119;
    assign w_shr = 8'd119 - w_exp;

    always_comb begin
        if (w_exp == 8'd255) begin
            w_fmag = 32'hffff_ffff;
        end else if (w_exp == 8'd0) begin
            w_fmag = '0;
        end else if (w_exp >= 8'd119) begin
            if (w_shl >= 8'd9) w_fmag = 32'hffff_ffff;
            else w_fmag = {8'd0, w_man} << w_shl[3:0];
        end else begin
            if (w_shr >= 8'd24) w_fmag = '0;
            else w_fmag = {8'd0, w_man} >> w_shr[4:0];
        end
    end

    always_comb begin
        o_mag = '0;
        if (o_fs != '0) begin
            case (i_size)
                SZ_8: begin
                    if (i_type == TY_SGN && i_sample[7])
                        o_mag = {23'd0, 9'h100 - {1'b0, i_sample[7:0]}};
                    else
                        o_mag = {24'd0, i_sample[7:0]};
                end
                SZ_16: begin
                    if (i_type == TY_SGN && w_v16[15])
                        o_mag = {15'd0, 17'h10000 - {1'b0, w_v16}};
                    else
                        o_mag = {16'd0, w_v16};
                end
                default: begin
                    if (i_type == TY_FLT) o_mag = w_fmag;
                    else if (i_type == TY_SGN && w_v32[31]) o_mag = 32'd0 - w_v32;
                    else o_mag = w_v32;
                end
            endcase
        end
    end

endmodule

// ===== design/apl_div.sv =====
// ----------------------------------------------------------------------------
// apl_div
// Restoring divider, one quotient bit per cycle. Forms the rounded
// dividend peak * 2^16 + fs / 2 on start and divides it by fs.
// ----------------------------------------------------------------------------
module apl_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [31:0]                i_peak,
    input  logic [31:0]                i_fs,
    output logic [apl_pkg::LEVEL_W-1:0] o_quo,
    output apl_pkg::t_div_stat         o_stat
);
    import apl_pkg::*;

    logic [DIVD_W-1:0]  w_divd;
    logic [31:0]        r_rem;
    logic [LEVEL_W-1:0] r_low;
    logic [LEVEL_W-1:0] r_quo;
    logic [31:0]        r_div;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [32:0]        w_trial;
    logic               w_ge;

    assign w_divd  = {1'b0, i_peak, 16'd0} + {17'd0, 1'b0, i_fs[31:1]};
    assign w_trial = {r_rem, r_low[LEVEL_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= w_divd[DIVD_W-1:LEVEL_W];
                r_low  <= w_divd[LEVEL_W-1:0];
                r_div  <= i_fs;
                r_quo  <= '0;
                r_cnt  <= 5'(LEVEL_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? 32'(w_trial - {1'b0, r_div}) : w_trial[31:0];
                r_low <= {r_low[LEVEL_W-2:0], 1'b0};
                r_quo <= {r_quo[LEVEL_W-2:0], w_ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== design/audio_peak_level_meter.sv =====
// ----------------------------------------------------------------------------
// audio_peak_level_meter
// Peak level meter: tracks the largest sample magnitude over a buffer and
// reports it as a Q1.16 level of the format's full scale.
// ----------------------------------------------------------------------------
// An ordinary sample is registered in the idle state, then decoded and
// folded into the peak in the peak state. A sample marked last passes
// through the clip, load, divide and output states; in the divide state the
// restoring divider produces one of the 17 level bits per cycle. An
// unsupported format skips the divider and returns the held level with
// format_ok low. The result sits in an output register, so the next sample
// is taken while a level beat waits downstream.
module audio_peak_level_meter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [1:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  apl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output apl_pkg::t_out o_out_data
);
    import apl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEAK,
        S_CLIP,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [1:0]         r_size;
    logic [1:0]         r_type;
    logic               r_big;
    logic [31:0]        r_sample;
    logic               r_last;
    logic [31:0]        r_peak;
    logic [31:0]        r_fin;
    logic [31:0]        r_fs;
    logic [31:0]        r_clip;
    logic [LEVEL_W-1:0] r_held;
    logic               r_ok;
    logic               r_out_valid;
    t_out               r_out;

    logic [31:0]        w_mag;
    logic [31:0]        w_fs;
    logic [31:0]        n_peak;
    logic [LEVEL_W-1:0] w_quo;
    t_div_stat          w_div;
    logic               w_start;

    apl_dec u_dec (
        .i_sample (r_sample),
        .i_size   (r_size),
        .i_type   (r_type),
        .i_big    (r_big),
        .o_mag    (w_mag),
        .o_fs     (w_fs)
    );

    assign w_start = (r_state == S_LOAD);

    apl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_peak  (r_clip),
        .i_fs    (r_fs),
        .o_quo   (w_quo),
        .o_stat  (w_div)
    );

    assign n_peak = (w_mag > r_peak) ? w_mag : r_peak;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SZ_16;
            r_type <= TY_SGN;
            r_big  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE: r_size <= i_cfg_data;
                CFG_TYPE: r_type <= i_cfg_data;
                CFG_BE:   r_big  <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_peak      <= '0;
            r_held      <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sample <= i_in_data.sample_bits;
                        r_last   <= i_in_data.last;
                        r_state  <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    if (!r_last) begin
                        r_peak  <= n_peak;
                        r_state <= S_IDLE;
                    end else begin
                        r_peak <= '0;
                        r_fin  <= n_peak;
                        r_fs   <= w_fs;
                        if (w_fs == '0) begin
                            r_ok    <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_CLIP;
                        end
                    end
                end
                S_CLIP: begin
                    r_clip  <= (r_fin < r_fs) ? r_fin : r_fs;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_held  <= w_quo;
                        r_ok    <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.level     <= r_held;
                        r_out.format_ok <= r_ok;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div.busy)
        else $error("input ready while divider busy");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.level <= LEVEL_MAX)
        else $error("level above full scale");

    a_peak_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_peak == '0)
        else $error("peak not cleared at buffer end");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == S_DIV)
        else $error("divider done outside divide state");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("result not loaded to output");

endmodule

// ===== tb/sv/tb_audio_peak_level_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_peak_level_meter
// Self-checking bench for the peak level meter. Samples flow through a
// valid/ready driver fed from a queue, each accepted beat updates a local
// peak tracker, and every level beat is checked field by field against the
// oldest predicted level. Formats are reprogrammed only while the block is
// idle; a directed pass hits the format corners before randomized buffers
// with random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_audio_peak_level_meter;
    import apl_pkg::*;

    localparam logic [1:0] SZ_OTHER     = 2'd3;
    localparam logic [1:0] TY_OTHER     = 2'd3;
    localparam int         RANDOM_ITEMS = 1100;
    localparam int         SETTLE_CYCLES = 30;
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         IDLE_PCT     = 38;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_idx  = CFG_SIZE;
    logic [1:0] i_cfg_data = 2'd0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in        i_in_data  = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out       o_out_data;

    audio_peak_level_meter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // format in force and tracker state
    logic [1:0]  cur_size = SZ_16;
    logic [1:0]  cur_type = TY_SGN;
    logic        cur_be   = 1'b0;
    logic [31:0] peak_mag = '0;
    logic [16:0] held_lvl = '0;

    t_in  sample_q[$];
    t_out level_q[$];

    logic in_beat     = 1'b0;
    logic failed      = 1'b0;
    logic squeezed    = 1'b0;
    int   hold_left   = 0;
    int   level_beats = 0;
    int   sent        = 0;
    int   quiet       = 0;

    function automatic logic [31:0] full_scale(input logic [1:0] sz, input logic [1:0] ty);
        case (sz)
            SZ_8: begin
                if (ty == TY_UNS) return FS_8U;
                if (ty == TY_SGN) return FS_8S;
            end
            SZ_16: begin
                if (ty == TY_UNS) return FS_16U;
                if (ty == TY_SGN) return FS_16S;
            end
            SZ_32: begin
                if (ty == TY_UNS) return FS_32U;
                if (ty == TY_SGN || ty == TY_FLT) return FS_32S;
            end
            default: ;
        endcase
        return '0;
    endfunction

    // trunc(|f| * 2^31), saturating
    function automatic logic [31:0] float_to_mag(input logic [31:0] f);
        logic [7:0]  e;
        logic [31:0] m;
        e = f[30:23];
        m = {8'd0, 1'b1, f[22:0]};
        if (e == 8'hff) return '1;
        if (e == 8'h00) return '0;
        if (e >= 119) begin
            if (e - 119 >= 9) return '1;
            return m << (e - 119);
        end
        if (119 - e >= 24) return '0;
        return m >> (119 - e);
    endfunction

    function automatic logic [31:0] sample_magnitude(input logic [31:0] raw);
        logic [31:0] v;
        if (full_scale(cur_size, cur_type) == '0) return '0;
        case (cur_size)
            SZ_8: begin
                v = {24'd0, raw[7:0]};
                if (cur_type == TY_SGN && v[7]) v = 32'h100 - v;
            end
            SZ_16: begin
                v = cur_be ? {16'd0, raw[7:0], raw[15:8]} : {16'd0, raw[15:0]};
                if (cur_type == TY_SGN && v[15]) v = 32'h10000 - v;
            end
            default: begin
                v = cur_be ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
                if (cur_type == TY_FLT) v = float_to_mag(v);
                else if (cur_type == TY_SGN && v[31]) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic void track_sample(input t_in s);
        logic [31:0] fs;
        logic [31:0] mag;
        logic [63:0] clipped;
        t_out        r;
        mag = sample_magnitude(s.sample_bits);
        if (mag > peak_mag) peak_mag = mag;
        if (s.last) begin
            fs = full_scale(cur_size, cur_type);
            if (fs != '0) begin
                clipped  = (peak_mag < fs) ? peak_mag : fs;
                held_lvl = 17'(((clipped << 16) + fs / 2) / fs);
            end
            peak_mag    = '0;
            r.level     = held_lvl;
            r.format_ok = (fs != '0);
            level_q.push_back(r);
        end
    endfunction

    function automatic logic [31:0] pick_sample();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom();
            4: v = $urandom() >> $urandom_range(31);
            5, 6: begin
                case ($urandom_range(7))
                    0: v = 32'h0000_0000;
                    1: v = 32'hffff_ffff;
                    2: v = 32'h8000_0000;
                    3: v = 32'h7fff_ffff;
                    4: v = 32'h0000_8000;
                    5: v = 32'h0000_7fff;
                    6: v = 32'h0000_0080;
                    default: v = 32'h0000_007f;
                endcase
            end
            default: begin
                // float pattern around full scale
                v[31]    = 1'($urandom_range(1));
                v[30:23] = 8'($urandom_range(160, 100));
                v[22:0]  = 23'($urandom());
                if ($urandom_range(7) == 0) v[30:23] = $urandom_range(1) ? 8'hff : 8'h00;
                if (cur_be) v = {v[7:0], v[15:8], v[23:16], v[31:24]};
            end
        endcase
        return v;
    endfunction

    task automatic offer(input logic [31:0] bits, input logic last);
        sample_q.push_back({bits, last});
    endtask

    task automatic set_format(input logic [1:0] sz, input logic [1:0] ty, input logic be);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SIZE;
        i_cfg_data <= sz;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_TYPE;
        i_cfg_data <= ty;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_BE;
        i_cfg_data <= {1'b0, be};
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_size = sz;
        cur_type = ty;
        cur_be   = be;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_q.size() != 0 || i_in_valid || level_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat) begin
            if (sample_q.size() != 0 &&
                ((sent >= 500 && sent < 700) || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_data  <= sample_q.pop_front();
                i_in_valid <= 1'b1;
                sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // level receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!squeezed && level_beats >= 40) begin
            hold_left   <= HOLD_CYCLES;
            squeezed    <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (level_beats >= 60 && level_beats < 100) ||
                           $urandom_range(99) >= IDLE_PCT;
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin : monitor
        t_out want;
        in_beat <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) track_sample(i_in_data);
            if (o_out_valid && i_out_ready) begin
                level_beats++;
                if (level_q.size() == 0) begin
                    $error("level beat with nothing expected: level %0d format_ok %0d",
                           o_out_data.level, o_out_data.format_ok);
                    failed = 1'b1;
                end else begin
                    want = level_q.pop_front();
                    if (o_out_data.level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, o_out_data.level);
                        failed = 1'b1;
                    end
                    if (o_out_data.format_ok !== want.format_ok) begin
                        $error("format_ok: expected %0d, got %0d",
                               want.format_ok, o_out_data.format_ok);
                        failed = 1'b1;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int         n;
        int         random_sent;
        logic [1:0] sz;
        logic [1:0] ty;
        random_sent = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset format, 16 bit signed little endian
        offer(32'hdead_8000, 1'b1);
        offer(32'h0000_0001, 1'b0);
        offer(32'h0000_7fff, 1'b1);
        offer(32'h0000_0000, 1'b1);
        wait_idle();

        // 8 bit unsigned, high bytes ignored
        set_format(SZ_8, TY_UNS, 1'b0);
        offer(32'h1234_56ff, 1'b1);
        wait_idle();

        // 8 bit signed ignores byte order, most negative code
        set_format(SZ_8, TY_SGN, 1'b1);
        offer(32'h0000_0080, 1'b1);
        offer(32'h0000_00c0, 1'b1);
        wait_idle();

        set_format(SZ_16, TY_UNS, 1'b1);
        offer(32'h0000_00ff, 1'b1);
        wait_idle();

        set_format(SZ_32, TY_UNS, 1'b0);
        offer(32'hffff_ffff, 1'b1);
        offer(32'h8000_0000, 1'b1);
        wait_idle();

        set_format(SZ_32, TY_SGN, 1'b1);
        offer(32'h0000_0080, 1'b1);
        offer(32'h0100_0000, 1'b1);
        wait_idle();

        // float: one, infinity, nan, subnormal, negative zero, tiny, negative half
        set_format(SZ_32, TY_FLT, 1'b0);
        offer(32'h3f80_0000, 1'b0);
        offer(32'h7f80_0000, 1'b0);
        offer(32'h7fc0_0000, 1'b1);
        offer(32'h0000_0001, 1'b0);
        offer(32'h8000_0000, 1'b0);
        offer(32'h3400_0000, 1'b1);
        offer(32'hbf00_0000, 1'b1);
        wait_idle();

        // unsupported formats hold the level
        set_format(SZ_8, TY_FLT, 1'b0);
        offer(32'h3f80_0000, 1'b1);
        wait_idle();
        set_format(SZ_OTHER, TY_SGN, 1'b0);
        offer(32'h7fff_ffff, 1'b1);
        wait_idle();
        set_format(SZ_16, TY_OTHER, 1'b0);
        offer(32'h0000_1234, 1'b1);
        wait_idle();

        // peak survives a format change mid-buffer
        set_format(SZ_16, TY_SGN, 1'b0);
        offer(32'h0000_4000, 1'b0);
        wait_idle();
        set_format(SZ_8, TY_UNS, 1'b0);
        offer(32'h0000_0010, 1'b1);
        wait_idle();

        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(4) != 0) begin
                case ($urandom_range(6))
                    0: begin sz = SZ_8;  ty = TY_UNS; end
                    1: begin sz = SZ_8;  ty = TY_SGN; end
                    2: begin sz = SZ_16; ty = TY_UNS; end
                    3: begin sz = SZ_16; ty = TY_SGN; end
                    4: begin sz = SZ_32; ty = TY_UNS; end
                    5: begin sz = SZ_32; ty = TY_SGN; end
                    default: begin sz = SZ_32; ty = TY_FLT; end
                endcase
            end else begin
                sz = 2'($urandom_range(3));
                ty = 2'($urandom_range(3));
            end
            set_format(sz, ty, 1'($urandom_range(1)));
            n = $urandom_range(80, 10);
            repeat (n) offer(pick_sample(), $urandom_range(7) == 0);
            random_sent += n;
            wait_idle();
        end

        if (!failed && level_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== audio_peak_level_meter.f =====
design/apl_pkg.sv
design/apl_dec.sv
design/apl_div.sv
design/audio_peak_level_meter.sv
tb/sv/tb_audio_peak_level_meter.sv
